// ----- src/bir_pkg.sv -----
// Shared types and constants for the bilinear image resampler.
// Used by bir_ctrl, bir_datapath and bilinear_image_resampler; no dependencies.
`timescale 1ns / 1ps

package bir_pkg;

    localparam int DEF_MAX_SOURCE_DIM = 512;
    localparam int DEF_MAX_OUTPUT_DIM = 2048;

    localparam int COORD_W = 11;
    localparam int PIXEL_W = 8;
    localparam int SIZE_W  = 10;
    localparam int SCALE_W = 24;
    localparam int POS_W   = COORD_W + SCALE_W;
    localparam int IX_W    = POS_W - 16;
    localparam int FRAC_W  = 8;
    localparam int WGT_W   = 2 * (FRAC_W + 1) - 1;
    localparam int ACC_W   = 24;
    localparam int TDATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 2'd3;

    localparam logic [SIZE_W-1:0]  RST_SOURCE_WIDTH  = 10'd512;
    localparam logic [SIZE_W-1:0]  RST_SOURCE_HEIGHT = 10'd512;
    localparam logic [SCALE_W-1:0] RST_SCALE_X       = 24'd23967;
    localparam logic [SCALE_W-1:0] RST_SCALE_Y       = 24'd23967;

    localparam logic [1:0] NB_TOP_LEFT     = 2'd0;
    localparam logic [1:0] NB_TOP_RIGHT    = 2'd1;
    localparam logic [1:0] NB_BOTTOM_LEFT  = 2'd2;
    localparam logic [1:0] NB_BOTTOM_RIGHT = 2'd3;

    typedef struct packed {
        logic       latch_in;
        logic       write_px;
        logic       do_mul;
        logic       do_addr;
        logic       issue;
        logic       accum;
        logic [1:0] nb_sel;
        logic       load_out;
    } t_bir_cmd;

    typedef struct packed {
        logic load_ok;
        logic sample_ok;
        logic out_free;
    } t_bir_status;

endpackage

// ----- src/bilinear_image_resampler.sv -----
// Top level of the bilinear image resampler: controller plus datapath.
// Depends on bir_pkg, bir_ctrl and bir_datapath.
`timescale 1ns / 1ps

// A load item (tuser 0) writes one pixel into the frame store and the block
// takes the next item in the following cycle. A sample item (tuser 1) keeps
// the block busy from its acceptance until its sum is moved into the result
// register, so no new item is taken meanwhile. In turn the block scales the
// coordinate, clamps the corner, reads the four neighbours through the single
// read port of the frame store and accumulates their weighted sum, and moves
// the sum into the result register once that register is free. A load or
// sample outside the store or output range is consumed without effect.
// Reading a store entry that was never loaded gives an undefined pixel.

module bilinear_image_resampler #(
    parameter int MAX_SOURCE_DIM = bir_pkg::DEF_MAX_SOURCE_DIM,
    parameter int MAX_OUTPUT_DIM = bir_pkg::DEF_MAX_OUTPUT_DIM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // coord_x[10:0], coord_y[21:11], pixel_in[29:22], zero[31:30]
    input  logic [bir_pkg::TDATA_W-1:0]    s_axis_tdata,
    // func[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_out[7:0], out_x[18:8], out_y[29:19], zero[31:30]
    output logic [bir_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bir_pkg::t_bir_cmd    cmd;
    bir_pkg::t_bir_status status;

    assign o_cfg_ready = 1'b1;

    bir_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    bir_datapath #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .MAX_OUTPUT_DIM (MAX_OUTPUT_DIM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

// ----- src/bir_ctrl.sv -----
// Sequencer for the bilinear image resampler.
// Drives the datapath commands; depends on bir_pkg.
`timescale 1ns / 1ps

module bir_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  bir_pkg::t_bir_status i_status,
    output bir_pkg::t_bir_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = accept;
                o_cmd.write_px = accept && i_status.load_ok;
                if (accept && i_status.sample_ok) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.do_addr = 1'b1;
                n_step        = '0;
                n_state       = S_RUN;
            end
            S_RUN: begin
                o_cmd.issue  = (r_step != STEP_LAST);
                o_cmd.accum  = (r_step != 3'd0);
                o_cmd.nb_sel = r_step[1:0];
                n_step       = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load_out = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.sample_ok) |=> (r_state == S_MUL))
        else $error("accepted sample did not start the sequence");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= STEP_LAST))
        else $error("neighbour step counter out of range");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_status.out_free) |=> (r_state == S_IDLE))
        else $error("finished sample did not release the block");

endmodule

// ----- src/bir_datapath.sv -----
// Datapath of the bilinear image resampler: registers, frame store, arithmetic.
// Follows commands from bir_ctrl; depends on bir_pkg.
`timescale 1ns / 1ps

module bir_datapath #(
    parameter int MAX_SOURCE_DIM = bir_pkg::DEF_MAX_SOURCE_DIM,
    parameter int MAX_OUTPUT_DIM = bir_pkg::DEF_MAX_OUTPUT_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bir_pkg::TDATA_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bir_pkg::TDATA_W-1:0]       m_axis_tdata,
    input  logic                              i_cfg_valid,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bir_pkg::t_bir_cmd                 i_cmd,
    output bir_pkg::t_bir_status              o_status
);

    localparam int CW    = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = bir_pkg::IX_W + 1;
    localparam int OCW   = bir_pkg::COORD_W + 2;

    logic [bir_pkg::SIZE_W-1:0]  r_src_w, r_src_h;
    logic [bir_pkg::SCALE_W-1:0] r_scale_x, r_scale_y;

    logic [bir_pkg::COORD_W-1:0] r_cx, r_cy;
    logic [bir_pkg::POS_W-1:0]   r_xp, r_yp;
    logic [CW-1:0]               r_ax, r_bx, r_ay, r_by;
    logic [bir_pkg::FRAC_W-1:0]  r_fx, r_fy;
    logic [bir_pkg::WGT_W-1:0]   r_wgt;
    logic [bir_pkg::PIXEL_W-1:0] r_rd_data;
    logic [bir_pkg::ACC_W-1:0]   r_acc;
    logic                        r_out_valid;
    logic [bir_pkg::PIXEL_W-1:0] r_out_px;
    logic [bir_pkg::COORD_W-1:0] r_out_x, r_out_y;

    logic [bir_pkg::PIXEL_W-1:0] r_frame_store [0:DEPTH-1];

    logic [bir_pkg::COORD_W-1:0] in_x, in_y;
    logic [bir_pkg::PIXEL_W-1:0] in_px;
    logic [XW-1:0]               w_lim, h_lim, ix, iy, ix1, iy1;
    logic [XW-1:0]               ax_c, bx_c, ay_c, by_c;
    logic [CW-1:0]               nb_x, nb_y;
    logic [bir_pkg::FRAC_W:0]    wx, wy, gx, gy;
    logic [bir_pkg::ACC_W:0]     term;

    assign in_x  = s_axis_tdata[bir_pkg::COORD_W-1:0];
    assign in_y  = s_axis_tdata[2*bir_pkg::COORD_W-1:bir_pkg::COORD_W];
    assign in_px = s_axis_tdata[2*bir_pkg::COORD_W+bir_pkg::PIXEL_W-1:2*bir_pkg::COORD_W];

    assign o_status.load_ok   = !s_axis_tuser
        && ({1'b0, in_x} < (bir_pkg::COORD_W+1)'(MAX_SOURCE_DIM))
        && ({1'b0, in_y} < (bir_pkg::COORD_W+1)'(MAX_SOURCE_DIM));
    assign o_status.sample_ok = s_axis_tuser
        && ({2'b0, in_x} < OCW'(MAX_OUTPUT_DIM))
        && ({2'b0, in_y} < OCW'(MAX_OUTPUT_DIM));
    assign o_status.out_free  = !r_out_valid || m_axis_tready;

    function automatic logic [XW-1:0] last_index(input logic [bir_pkg::SIZE_W-1:0] size);
        logic [XW-1:0] ext;
        begin
            ext = XW'(size);
            if (size == '0) begin
                last_index = '0;
            end else if (ext > XW'(MAX_SOURCE_DIM)) begin
                last_index = XW'(MAX_SOURCE_DIM - 1);
            end else begin
                last_index = ext - XW'(1);
            end
        end
    endfunction

    always_comb begin
        w_lim = last_index(r_src_w);
        h_lim = last_index(r_src_h);
        ix    = XW'(r_xp[bir_pkg::POS_W-1:16]);
        iy    = XW'(r_yp[bir_pkg::POS_W-1:16]);
        ix1   = ix + XW'(1);
        iy1   = iy + XW'(1);
        ax_c  = (ix  > w_lim) ? w_lim : ix;
        bx_c  = (ix1 > w_lim) ? w_lim : ix1;
        ay_c  = (iy  > h_lim) ? h_lim : iy;
        by_c  = (iy1 > h_lim) ? h_lim : iy1;
    end

    always_comb begin
        gx = 9'd256 - {1'b0, r_fx};
        gy = 9'd256 - {1'b0, r_fy};
        case (i_cmd.nb_sel)
            bir_pkg::NB_TOP_LEFT: begin
                nb_x = r_ax; nb_y = r_ay; wx = gx; wy = gy;
            end
            bir_pkg::NB_TOP_RIGHT: begin
                nb_x = r_bx; nb_y = r_ay; wx = {1'b0, r_fx}; wy = gy;
            end
            bir_pkg::NB_BOTTOM_LEFT: begin
                nb_x = r_ax; nb_y = r_by; wx = gx; wy = {1'b0, r_fy};
            end
            bir_pkg::NB_BOTTOM_RIGHT: begin
                nb_x = r_bx; nb_y = r_by; wx = {1'b0, r_fx}; wy = {1'b0, r_fy};
            end
            default: begin
                nb_x = r_ax; nb_y = r_ay; wx = gx; wy = gy;
            end
        endcase
    end

    assign term = (bir_pkg::ACC_W+1)'(r_rd_data) * (bir_pkg::ACC_W+1)'(r_wgt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= bir_pkg::RST_SOURCE_WIDTH;
            r_src_h   <= bir_pkg::RST_SOURCE_HEIGHT;
            r_scale_x <= bir_pkg::RST_SCALE_X;
            r_scale_y <= bir_pkg::RST_SCALE_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bir_pkg::REG_SOURCE_WIDTH:  r_src_w   <= i_cfg_data[bir_pkg::SIZE_W-1:0];
                bir_pkg::REG_SOURCE_HEIGHT: r_src_h   <= i_cfg_data[bir_pkg::SIZE_W-1:0];
                bir_pkg::REG_SCALE_X:       r_scale_x <= i_cfg_data;
                bir_pkg::REG_SCALE_Y:       r_scale_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cx  <= in_x;
            r_cy  <= in_y;
        end
        if (i_cmd.do_mul) begin
            r_xp <= bir_pkg::POS_W'(r_cx) * bir_pkg::POS_W'(r_scale_x);
            r_yp <= bir_pkg::POS_W'(r_cy) * bir_pkg::POS_W'(r_scale_y);
        end
        if (i_cmd.do_addr) begin
            r_ax <= ax_c[CW-1:0];
            r_bx <= bx_c[CW-1:0];
            r_ay <= ay_c[CW-1:0];
            r_by <= by_c[CW-1:0];
            r_fx <= r_xp[15:8];
            r_fy <= r_yp[15:8];
        end
        if (i_cmd.issue) begin
            r_wgt <= bir_pkg::WGT_W'(wx) * bir_pkg::WGT_W'(wy);
        end
        if (i_cmd.do_addr) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= r_acc + term[bir_pkg::ACC_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_px <= r_acc[bir_pkg::ACC_W-1:bir_pkg::ACC_W-bir_pkg::PIXEL_W];
            r_out_x  <= r_cx;
            r_out_y  <= r_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_px) begin
            r_frame_store[{in_y[CW-1:0], in_x[CW-1:0]}] <= in_px;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_frame_store[{nb_y, nb_x}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_y, r_out_x, r_out_px};

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> m_axis_tvalid)
        else $error("result was not presented after loading");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_px |-> !i_cmd.issue)
        else $error("frame store written during a neighbour read");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("waiting result changed before it was taken");

endmodule
